// File: sv/psab_pkg.sv
package psab_pkg;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int SPRITE_MAX_DEF    = 1024;

    localparam int ADDR_W    = 19;
    localparam int COLOR_W   = 24;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = 8;
    localparam int PADDR_W   = 5;

    localparam logic [8:0]  ALPHA_FULL = 9'd256;
    localparam logic [10:0] WIDTH_RST  = 11'd1;

    typedef enum logic [2:0] {
        REG_OFFSET_X     = 3'd0,
        REG_OFFSET_Y     = 3'd1,
        REG_SPRITE_WIDTH = 3'd2,
        REG_KEY_INDEX    = 3'd3,
        REG_MIRROR       = 3'd4,
        REG_ALPHA        = 3'd5,
        REG_RASTER_MODE  = 3'd6,
        REG_SCROLL       = 3'd7
    } t_reg;

    typedef struct packed {
        logic [11:0] offset_x;
        logic [11:0] offset_y;
        logic [10:0] sprite_width;
        logic [7:0]  key_index;
        logic        mirror;
        logic [8:0]  alpha;
        logic        raster_mode;
        logic [7:0]  scroll;
    } t_cfg;

    // Item state handed from placement to blending
    typedef struct packed {
        logic                keep;
        logic [10:0]         px;
        logic [ADDR_W-1:0]   row;
        logic [COLOR_W-1:0]  bg;
    } t_s2;

endpackage

// File: sv/psab_ram.sv
module psab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/psab_place.sv
module psab_place #(
    parameter int SCREEN_WIDTH  = psab_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = psab_pkg::SCREEN_HEIGHT_DEF,
    parameter int SPRITE_MAX    = psab_pkg::SPRITE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic                          i_op,
    input  logic [7:0]                    i_index,
    input  logic [9:0]                    i_src_x,
    input  logic [9:0]                    i_src_y,
    input  logic [psab_pkg::COLOR_W-1:0]  i_bg,
    input  psab_pkg::t_cfg                i_cfg,
    output logic [psab_pkg::PAL_AW-1:0]   o_entry,
    output logic                          o_valid,
    output psab_pkg::t_s2                 o_s2
);

    logic [13:0] w_sx;
    logic [13:0] w_px;
    logic [12:0] w_py;
    logic        w_keep;

    logic                         r1_v;
    logic                         r1_keep;
    logic [13:0]                  r1_px;
    logic [12:0]                  r1_py;
    logic [7:0]                   r1_idx;
    logic [psab_pkg::COLOR_W-1:0] r1_bg;

    logic                 w_onscreen;
    psab_pkg::t_s2        n2_s2;
    logic                 r2_v;
    psab_pkg::t_s2        r2_s2;

    // Stage 0: screen position in two's complement
    always_comb begin
        if (i_cfg.mirror) begin
            w_sx = {3'b0, i_cfg.sprite_width} - 14'd1 - {4'b0, i_src_x};
        end else begin
            w_sx = {4'b0, i_src_x};
        end
        w_px   = {{2{i_cfg.offset_x[11]}}, i_cfg.offset_x} + w_sx;
        w_py   = {i_cfg.offset_y[11], i_cfg.offset_y} + {3'b0, i_src_y};
        w_keep = i_op && (i_index != i_cfg.key_index) && (i_cfg.alpha != 9'd0) &&
                 (13'(i_src_x) < 13'(SPRITE_MAX)) && (13'(i_src_y) < 13'(SPRITE_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_keep <= w_keep;
            r1_px   <= w_px;
            r1_py   <= w_py;
            r1_idx  <= i_index;
            r1_bg   <= i_bg;
            r2_s2   <= n2_s2;
        end
    end

    // Stage 1: clip, palette entry, row base
    always_comb begin
        w_onscreen = !r1_px[13] && (r1_px[12:0] < 13'(SCREEN_WIDTH)) &&
                     !r1_py[12] && (r1_py[11:0] < 12'(SCREEN_HEIGHT));
        if (i_cfg.raster_mode) begin
            o_entry = r1_py[7:0] + {r1_py[5:0], 2'b00} + i_cfg.scroll;
        end else begin
            o_entry = r1_idx;
        end
        n2_s2.keep = r1_keep && w_onscreen;
        n2_s2.px   = r1_px[10:0];
        n2_s2.row  = psab_pkg::ADDR_W'(r1_py[10:0]) *
                     psab_pkg::ADDR_W'(SCREEN_WIDTH);
        n2_s2.bg   = r1_bg;
    end

    assign o_valid = r2_v;
    assign o_s2    = r2_s2;

endmodule

// File: sv/psab_blend.sv
module psab_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  psab_pkg::t_s2                 i_s2,
    input  logic [psab_pkg::COLOR_W-1:0]  i_color,
    input  logic [8:0]                    i_alpha,
    output logic                          o_valid,
    output logic                          o_we,
    output logic [psab_pkg::ADDR_W-1:0]   o_addr,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue
);

    logic [8:0]  w_a;
    logic [8:0]  w_na;

    logic                        r3_v;
    logic                        r3_keep;
    logic [psab_pkg::ADDR_W-1:0] r3_addr;
    logic [16:0]                 r3_pc [3];
    logic [16:0]                 r3_pb [3];

    logic [16:0] w_sum [3];

    logic                        r4_v;
    logic                        r4_we;
    logic [psab_pkg::ADDR_W-1:0] r4_addr;
    logic [7:0]                  r4_col [3];

    // Saturate alpha above full scale
    always_comb begin
        w_a  = i_alpha[8] ? psab_pkg::ALPHA_FULL : i_alpha;
        w_na = psab_pkg::ALPHA_FULL - w_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= i_valid;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_keep <= i_s2.keep;
            r3_addr <= i_s2.row + psab_pkg::ADDR_W'(i_s2.px);
            for (int k = 0; k < 3; k++) begin
                r3_pc[k] <= 17'(w_a) * 17'(i_color[8*k +: 8]);
                r3_pb[k] <= 17'(w_na) * 17'(i_s2.bg[8*k +: 8]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = r3_pc[k] + r3_pb[k];
        end
    end

    // Drop the payload to zero when nothing is written
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_we   <= r3_keep;
            r4_addr <= r3_keep ? r3_addr : '0;
            for (int k = 0; k < 3; k++) begin
                r4_col[k] <= r3_keep ? w_sum[k][15:8] : 8'd0;
            end
        end
    end

    assign o_valid = r4_v;
    assign o_we    = r4_we;
    assign o_addr  = r4_addr;
    assign o_blue  = r4_col[0];
    assign o_green = r4_col[1];
    assign o_red   = r4_col[2];

endmodule

// File: sv/palette_sprite_alpha_blit_unit.sv
// Channel | Dir | tdata (low bit up)                                  | tuser
// s_      | in  | index, src_x, src_y, red, green, blue, bg_red,       | op
//         |     | bg_green, bg_blue, 4 zero bits (80 bits)            |
// m_      | out | pixel_address, out_red, out_green, out_blue,        | write_enable
//         |     | 5 zero bits (48 bits)                               |
// apb     | in  | offset_x..scroll at byte addresses 0,4,..,28        | -
//
// One item per cycle unless a held output stalls the pipe; every item gives one result.
// Four register stages: placement, clip with palette read, multiply, sum.
// All stages advance together; a held output stalls the whole pipe, nothing is lost.
// Reset clears valid bits, sets sprite width to 1 and alpha to full scale, and zeroes
// the other configuration registers; the palette holds nothing until loaded.
module palette_sprite_alpha_blit_unit #(
    parameter int SCREEN_WIDTH  = psab_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = psab_pkg::SCREEN_HEIGHT_DEF,
    parameter int SPRITE_MAX    = psab_pkg::SPRITE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [79:0]                   i_s_tdata,  // index, src_x, src_y, red, green,
                                                      // blue, bg_red, bg_green, bg_blue
    input  logic                          i_s_tuser,  // op
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [47:0]                   o_m_tdata,  // pixel_address, out_red,
                                                      // out_green, out_blue
    output logic                          o_m_tuser,  // write_enable
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psab_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    psab_pkg::t_cfg r_cfg;
    logic           w_adv;
    logic           w_in_xfer;

    logic [psab_pkg::PAL_AW-1:0]  w_entry;
    logic [psab_pkg::COLOR_W-1:0] w_color;
    logic                         w_v2;
    psab_pkg::t_s2                w_s2;

    logic                        w_we;
    logic [psab_pkg::ADDR_W-1:0] w_addr;
    logic [7:0]                  w_red;
    logic [7:0]                  w_green;
    logic [7:0]                  w_blue;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x     <= '0;
            r_cfg.offset_y     <= '0;
            r_cfg.sprite_width <= psab_pkg::WIDTH_RST;
            r_cfg.key_index    <= '0;
            r_cfg.mirror       <= 1'b0;
            r_cfg.alpha        <= psab_pkg::ALPHA_FULL;
            r_cfg.raster_mode  <= 1'b0;
            r_cfg.scroll       <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (psab_pkg::t_reg'(paddr[4:2]))
                psab_pkg::REG_OFFSET_X:     r_cfg.offset_x     <= pwdata[11:0];
                psab_pkg::REG_OFFSET_Y:     r_cfg.offset_y     <= pwdata[11:0];
                psab_pkg::REG_SPRITE_WIDTH: r_cfg.sprite_width <= pwdata[10:0];
                psab_pkg::REG_KEY_INDEX:    r_cfg.key_index    <= pwdata[7:0];
                psab_pkg::REG_MIRROR:       r_cfg.mirror       <= pwdata[0];
                psab_pkg::REG_ALPHA:        r_cfg.alpha        <= pwdata[8:0];
                psab_pkg::REG_RASTER_MODE:  r_cfg.raster_mode  <= pwdata[0];
                psab_pkg::REG_SCROLL:       r_cfg.scroll       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (psab_pkg::t_reg'(paddr[4:2]))
            psab_pkg::REG_OFFSET_X:     prdata = 32'(r_cfg.offset_x);
            psab_pkg::REG_OFFSET_Y:     prdata = 32'(r_cfg.offset_y);
            psab_pkg::REG_SPRITE_WIDTH: prdata = 32'(r_cfg.sprite_width);
            psab_pkg::REG_KEY_INDEX:    prdata = 32'(r_cfg.key_index);
            psab_pkg::REG_MIRROR:       prdata = 32'(r_cfg.mirror);
            psab_pkg::REG_ALPHA:        prdata = 32'(r_cfg.alpha);
            psab_pkg::REG_RASTER_MODE:  prdata = 32'(r_cfg.raster_mode);
            psab_pkg::REG_SCROLL:       prdata = 32'(r_cfg.scroll);
            default:                    prdata = '0;
        endcase
    end

    // Advance the pipe unless the output holds a result nobody takes
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    psab_place #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .SPRITE_MAX    (SPRITE_MAX)
    ) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_index (i_s_tdata[7:0]),
        .i_src_x (i_s_tdata[17:8]),
        .i_src_y (i_s_tdata[27:18]),
        .i_bg    ({i_s_tdata[59:52], i_s_tdata[67:60], i_s_tdata[75:68]}),
        .i_cfg   (r_cfg),
        .o_entry (w_entry),
        .o_valid (w_v2),
        .o_s2    (w_s2)
    );

    // Palette load on its input transfer; later draws read after it
    psab_ram #(
        .WIDTH (psab_pkg::COLOR_W),
        .DEPTH (psab_pkg::PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_in_xfer && !i_s_tuser),
        .i_waddr (i_s_tdata[7:0]),
        .i_wdata ({i_s_tdata[35:28], i_s_tdata[43:36], i_s_tdata[51:44]}),
        .i_re    (w_adv),
        .i_raddr (w_entry),
        .o_rdata (w_color)
    );

    psab_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_v2),
        .i_s2    (w_s2),
        .i_color (w_color),
        .i_alpha (r_cfg.alpha),
        .o_valid (o_m_tvalid),
        .o_we    (w_we),
        .o_addr  (w_addr),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign o_m_tuser = w_we;
    assign o_m_tdata = {5'b0, w_blue, w_green, w_red, w_addr};

endmodule

// File: sv/psab_check.sv
module psab_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output changed while stalled");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 48'd0)
        else $error("payload not zero without write");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser) ##1 i_m_tready ##1 i_m_tready
        ##1 i_m_tready |=> o_m_tvalid && !o_m_tuser)
        else $error("palette load result missing or writes");

endmodule

bind palette_sprite_alpha_blit_unit psab_check u_psab_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
